>>> sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the table search comparison counter.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int SIZE_W  = 8;    // size register width
  localparam int INDEX_W = 7;    // entry_index / found_index width
  localparam int MODE_W  = 2;
  localparam int OUT_CNT_W = 9;  // comparison_count port width
  localparam int COUNT_W = 10;   // internal count, holds 2*255+3
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(511);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR   = 2'd0,
    MODE_SENTINEL = 2'd1,
    MODE_ORDERED  = 2'd2,
    MODE_BINARY   = 2'd3
  } mode_t;

  // result of one entry-versus-key compare
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

>>> sv/sts_if.sv
// ----------------------------------------------------------------------------
// sts_if
// Valid/ready channels: search/load items in, search results out.
// ----------------------------------------------------------------------------
interface sts_item_if #(parameter int VALUE_WIDTH = 32);
  import sts_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [INDEX_W-1:0]            entry_index;
  logic signed [VALUE_WIDTH-1:0] data_value;
  logic [MODE_W-1:0]             search_mode;

  modport source (output valid, command, entry_index, data_value, search_mode,
                  input ready);
  modport sink   (input valid, command, entry_index, data_value, search_mode,
                  output ready);
endinterface

interface sts_result_if;
  import sts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_CNT_W-1:0] comparison_count;
  logic                 found;
  logic [INDEX_W-1:0]   found_index;

  modport source (output valid, comparison_count, found, found_index, input ready);
  modport sink   (input valid, comparison_count, found, found_index, output ready);
endinterface

>>> sv/table_search_comparison_counter_unit.sv
// ----------------------------------------------------------------------------
// table_search_comparison_counter_unit
// Loads a table of signed words and runs linear, sentinel, ordered sentinel
// or binary searches over it, reporting the comparison count and match.
// ----------------------------------------------------------------------------
// Load: writes one table entry, no result word. Search: a fetch, then one
//   compare per entry for the linear modes, up to the match or the last
//   entry; binary takes a fetch and a compare per probe. An emit step then
//   posts the result, waiting while a stalled result word is still held.
// Items are taken only in the idle state, so a new search waits until the
//   last result is posted; the single table read port feeds the one shared comparator.
// Reset clears control and sets size_reg to 128; table contents stay
//   undefined until loaded.
module table_search_comparison_counter_unit #(
  parameter int TABLE_DEPTH = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [sts_pkg::SIZE_W-1:0] cfg_wdata,
  sts_item_if.sink                item,
  sts_result_if.source            result
);
  import sts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW = (AW > SIZE_W) ? AW : SIZE_W;
  localparam logic [PW:0] DEPTH_P = (PW+1)'(TABLE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_COMPARE, ST_EMIT} state_t;

  state_t                  state;
  logic [SIZE_W-1:0]       size_reg;
  logic [VALUE_WIDTH-1:0]  key;
  mode_t                   mode;
  logic [PW-1:0]           probe;
  logic [PW-1:0]           last_pos;
  logic signed [PW:0]      left;
  logic signed [PW:0]      right;
  logic [COUNT_W-1:0]      count;
  logic                    res_found;
  logic [INDEX_W-1:0]      res_index;
  logic [COUNT_W-1:0]      res_count;

  logic                    out_valid;
  logic [OUT_CNT_W-1:0]    out_count;
  logic                    out_found;
  logic [INDEX_W-1:0]      out_index;

  // effective size: zero acts as one, clamp to table depth
  logic [PW:0]             size_ext;
  logic [PW:0]             n_eff;
  logic signed [PW+1:0]    bound_sum;
  logic [PW-1:0]           mid;

  logic                    item_acc;
  logic                    load_we;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [VALUE_WIDTH-1:0]  rd_data;
  cmp_res_t                cmp;

  logic [COUNT_W-1:0]      count_next;
  logic                    done_next;
  logic                    found_next;
  logic signed [PW:0]      left_next;
  logic signed [PW:0]      right_next;
  logic                    is_last;
  logic signed [PW:0]      probe_s;

  assign size_ext  = (PW+1)'(size_reg);
  assign n_eff     = (size_reg == '0) ? (PW+1)'(1) :
                     ((size_ext > DEPTH_P) ? DEPTH_P : size_ext);
  assign bound_sum = (PW+2)'(left) + (PW+2)'(right);
  assign mid       = bound_sum[PW:1];   // left <= right here, so sum >= 0

  assign item.ready = (state == ST_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign load_we    = item_acc && (item.command == CMD_LOAD) &&
                      ((PW+1)'(item.entry_index) < DEPTH_P);

  assign result.valid            = out_valid;
  assign result.comparison_count = out_count;
  assign result.found            = out_found;
  assign result.found_index      = out_index;

  assign is_last = (probe == last_pos);
  assign probe_s = $signed({1'b0, probe});

  sts_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(item.entry_index)),
    .wdata (item.data_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sts_cmp #(
    .WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .entry (rd_data),
    .key   (key),
    .res   (cmp)
  );

  // read port: first fetch, then next entry while the linear scan runs on
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = probe[AW-1:0];
    if (state == ST_FETCH) begin
      rd_en   = 1'b1;
      rd_addr = (mode == MODE_BINARY) ? mid[AW-1:0] : probe[AW-1:0];
    end else if (state == ST_COMPARE && mode != MODE_BINARY) begin
      rd_en   = 1'b1;
      rd_addr = AW'(probe + PW'(1));
    end
  end

  // one compare step: count update and stop decision
  always_comb begin
    count_next = count;
    done_next  = 1'b0;
    found_next = 1'b0;
    left_next  = left;
    right_next = right;
    case (mode)
      MODE_LINEAR: begin
        if (cmp.eq) begin
          count_next = count + COUNT_W'(2);
          done_next  = 1'b1;
          found_next = 1'b1;
        end else if (is_last) begin
          count_next = count + COUNT_W'(3);
          done_next  = 1'b1;
        end else begin
          count_next = count + COUNT_W'(2);
        end
      end
      MODE_SENTINEL: begin
        if (cmp.eq) begin
          count_next = count + COUNT_W'(2);
          done_next  = 1'b1;
          found_next = 1'b1;
        end else if (is_last) begin
          count_next = count + COUNT_W'(3);
          done_next  = 1'b1;
        end else begin
          count_next = count + COUNT_W'(1);
        end
      end
      MODE_ORDERED: begin
        if (cmp.gt) begin
          count_next = count + COUNT_W'(1);
          done_next  = 1'b1;
        end else if (cmp.eq) begin
          count_next = count + COUNT_W'(3);
          done_next  = 1'b1;
          found_next = 1'b1;
        end else if (is_last) begin
          count_next = count + COUNT_W'(5);   // reached the sentinel
          done_next  = 1'b1;
        end else begin
          count_next = count + COUNT_W'(2);
        end
      end
      MODE_BINARY: begin
        if (cmp.eq) begin
          count_next = count + COUNT_W'(1);
          done_next  = 1'b1;
          found_next = 1'b1;
        end else begin
          if (cmp.gt) begin
            count_next = count + COUNT_W'(3);
            right_next = probe_s - (PW+1)'(1);
          end else begin
            count_next = count + COUNT_W'(4);
            left_next  = probe_s + (PW+1)'(1);
          end
          done_next = (left_next > right_next);
        end
      end
      default: begin
        done_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      size_reg  <= SIZE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_reg <= cfg_wdata;
      end
      // in ST_EMIT the emit step below owns out_valid
      if (result.valid && result.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_acc && item.command == CMD_SEARCH) begin
            key      <= item.data_value;
            mode     <= mode_t'(item.search_mode);
            probe    <= '0;
            last_pos <= PW'(n_eff - (PW+1)'(1));
            left     <= '0;
            right    <= $signed(n_eff - (PW+1)'(1));
            count    <= '0;
            state    <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (mode == MODE_BINARY) begin
            probe <= mid;
          end
          state <= ST_COMPARE;
        end
        ST_COMPARE: begin
          count <= count_next;
          left  <= left_next;
          right <= right_next;
          if (done_next) begin
            res_count <= count_next;
            res_found <= found_next;
            res_index <= found_next ? probe[INDEX_W-1:0] : '0;
            state     <= ST_EMIT;
          end else if (mode == MODE_BINARY) begin
            state <= ST_FETCH;
          end else begin
            probe <= probe + PW'(1);
          end
        end
        ST_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_count <= (res_count > COUNT_MAX) ? OUT_CNT_W'(COUNT_MAX)
                                                 : OUT_CNT_W'(res_count);
            out_found <= res_found;
            out_index <= res_index;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/sts_mem.sv
// ----------------------------------------------------------------------------
// sts_mem
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/sts_cmp.sv
// ----------------------------------------------------------------------------
// sts_cmp
// Shared signed comparator: table entry against search key.
// ----------------------------------------------------------------------------
module sts_cmp #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] entry,
  input  logic [WIDTH-1:0] key,
  output sts_pkg::cmp_res_t res
);
  import sts_pkg::*;

  always_comb begin
    res.eq = (entry == key);
    res.gt = ($signed(entry) > $signed(key));
  end

endmodule

>>> sv/sts_chk.sv
// ----------------------------------------------------------------------------
// sts_chk
// Port-level checks for the table search comparison counter.
// ----------------------------------------------------------------------------
module sts_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          item_command,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [sts_pkg::OUT_CNT_W-1:0] res_count,
  input logic                          res_found,
  input logic [sts_pkg::INDEX_W-1:0]   res_index
);
  import sts_pkg::*;

  // no result word right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_count) &&
    $stable(res_found) && $stable(res_index))
    else $error("stalled result word changed");

  // a search occupies the block for at least the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_command == CMD_SEARCH |=> !item_ready)
    else $error("ready right after a search was taken");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |-> res_index == '0)
    else $error("nonzero index on a miss");

  // every search makes at least one comparison
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_count != '0)
    else $error("zero comparison count");

endmodule

bind table_search_comparison_counter_unit sts_chk u_sts_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_command (item.command),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_count    (result.comparison_count),
  .res_found    (result.found),
  .res_index    (result.found_index)
);

>>> verif/tb_table_search_comparison_counter_unit.sv
// ----------------------------------------------------------------------------
// tb_table_search_comparison_counter_unit
// Self-checking bench for the table search comparison counter. It fills the
// table, runs directed searches at the value and size corners, then runs
// random phases over sorted and scattered tables under several size settings.
// Every search word is predicted at acceptance and its result is compared
// field by field, in order. Both channels idle and stall at random, except in
// the closing phases.
// ----------------------------------------------------------------------------
module tb_table_search_comparison_counter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam int DEPTH         = 128;
  localparam int VW            = 32;
  localparam int BLOCK_LATENCY = 140;      // worst-case search time, with margin
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 6;
  localparam int PHASE_SEARCHES = 70;

  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 found;
    logic [INDEX_W-1:0]   index;
  } search_outcome_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [SIZE_W-1:0]   cfg_wdata;

  sts_item_if #(.VALUE_WIDTH(VW)) item_ch ();
  sts_result_if                   res_ch ();

  table_search_comparison_counter_unit #(
    .TABLE_DEPTH(DEPTH),
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch)
  );

  // local copy of block state
  logic signed [VW-1:0] table_copy [DEPTH];
  logic [SIZE_W-1:0]    size_setting;
  search_outcome_t      pending_outcomes [$];

  bit idle_on;
  int stall_left;
  int cycle_count;
  int errors;
  int n_searches;
  int n_loads;
  int n_checked;
  int n_sizes;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending", cycle_count,
               pending_outcomes.size());
      $display("table_search_comparison_counter_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int eff_size();
    if (size_setting == 0) return 1;
    if (size_setting > DEPTH) return DEPTH;
    return int'(size_setting);
  endfunction

  function automatic search_outcome_t search_outcome(input logic signed [VW-1:0] key,
                                                     input mode_t mode);
    search_outcome_t r;
    int n, c, lo, hi, mid;
    logic hit, stop;
    n = eff_size();
    c = 0;
    hit = 1'b0;
    stop = 1'b0;
    r = '0;
    case (mode)
      MODE_LINEAR: begin
        for (int i = 0; i < n; i++) begin
          c++;
          if (table_copy[i] == key) begin
            hit = 1'b1;
            r.index = INDEX_W'(i);
            break;
          end
          c++;
        end
        c++;
      end
      MODE_SENTINEL: begin
        for (int i = 0; i < n; i++) begin
          c++;
          if (table_copy[i] == key) begin
            hit = 1'b1;
            r.index = INDEX_W'(i);
            break;
          end
        end
        // miss pays the sentinel hit as well as the end test
        c += hit ? 1 : 2;
      end
      MODE_ORDERED: begin
        for (int i = 0; i < n; i++) begin
          c++;
          if (table_copy[i] > key) begin
            stop = 1'b1;
            break;
          end
          c++;
          if (table_copy[i] == key) begin
            c++;
            hit = 1'b1;
            r.index = INDEX_W'(i);
            stop = 1'b1;
            break;
          end
        end
        if (!stop) c += 3;
      end
      default: begin
        lo = 0;
        hi = n - 1;
        forever begin
          mid = (lo + hi) / 2;
          c++;
          if (table_copy[mid] == key) begin
            hit = 1'b1;
            r.index = INDEX_W'(mid);
            break;
          end
          c++;
          if (table_copy[mid] > key) begin
            hi = mid - 1;
          end else begin
            c++;
            lo = mid + 1;
          end
          c++;
          if (lo > hi) break;
        end
      end
    endcase
    r.count = OUT_CNT_W'(c);
    r.found = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls and in-order check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    res_ch.ready <= (stall_left == 0);
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    search_outcome_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result word with no search pending");
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (res_ch.comparison_count !== want.count)
          flag_mismatch($sformatf("comparison_count got %0d want %0d",
                                  res_ch.comparison_count, want.count));
        if (res_ch.found !== want.found)
          flag_mismatch($sformatf("found got %0b want %0b", res_ch.found, want.found));
        if (res_ch.found_index !== want.index)
          flag_mismatch($sformatf("found_index got %0d want %0d",
                                  res_ch.found_index, want.index));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                           input logic signed [VW-1:0] val, input mode_t mode);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.command     <= cmd;
    item_ch.entry_index <= idx;
    item_ch.data_value  <= val;
    item_ch.search_mode <= mode;
    do @(posedge clk); while (!item_ch.ready);
    if (cmd == CMD_LOAD) begin
      table_copy[idx] = val;
      n_loads++;
    end else begin
      pending_outcomes.push_back(search_outcome(val, mode));
      n_searches++;
    end
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic signed [VW-1:0] val);
    send_word(CMD_LOAD, idx, val, mode_t'($urandom_range(0, 3)));
  endtask

  task automatic search_key(input logic signed [VW-1:0] key, input mode_t mode);
    send_word(CMD_SEARCH, INDEX_W'($urandom_range(0, DEPTH - 1)), key, mode);
  endtask

  // drain, then wait out a trailing load before touching the size register
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (BLOCK_LATENCY) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_setting = v;
    n_sizes++;
  endtask

  function automatic logic signed [VW-1:0] random_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed(VW'($urandom_range(0, 32))) - 16;
      2:       return table_copy[$urandom_range(0, DEPTH - 1)];
      default: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    endcase
  endfunction

  // mostly keys that sit in the searched range, some neighbors and noise
  function automatic logic signed [VW-1:0] pick_key();
    logic signed [VW-1:0] k;
    k = table_copy[$urandom_range(0, eff_size() - 1)];
    case ($urandom_range(0, 9))
      5:       k = k + 1;
      6:       k = k - 1;
      7:       k = $urandom;
      8:       k = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      default: ;
    endcase
    return k;
  endfunction

  task automatic reload_sorted();
    longint acc;
    acc = -64'sd2147483648 + $urandom_range(0, 4095);
    for (int i = 0; i < DEPTH; i++) begin
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      load_entry(INDEX_W'(i), VW'(acc));
      // small steps now and then leave runs of equal entries
      acc += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                         : $urandom_range(0, 32'h01FF_FFFF);
    end
  endtask

  task automatic scatter_loads(input int cnt);
    for (int i = 0; i < cnt; i++)
      load_entry(INDEX_W'($urandom_range(0, DEPTH - 1)), random_value());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // sorted ramp with the value extremes at both ends; every entry gets written
  task automatic test_table_fill();
    logic signed [VW-1:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) v = VAL_MIN;
      else if (i == DEPTH - 1) v = VAL_MAX;
      else v = i * 4096 - 262144;
      load_entry(INDEX_W'(i), v);
    end
  endtask

  // first entry, last entry, and a gap key that stops ordered search early
  task automatic test_edge_searches();
    for (int m = 0; m < 4; m++) begin
      search_key(VAL_MIN, mode_t'(m));
      search_key(VAL_MAX, mode_t'(m));
      search_key(table_copy[50] + 1, mode_t'(m));
    end
  endtask

  // size zero acts as one, oversize clamps to full depth
  task automatic test_size_corners();
    write_size(SIZE_W'(0));
    for (int m = 0; m < 4; m++) search_key(VAL_MAX, mode_t'(m));
    write_size(SIZE_W'(255));
    search_key(VAL_MAX, MODE_BINARY);
    search_key(table_copy[90], MODE_LINEAR);
    write_size(SIZE_W'(2));
    search_key(table_copy[1], MODE_ORDERED);
    search_key(table_copy[1] + 1, MODE_BINARY);
  endtask

  // even phases search a sorted table, odd phases a scattered one with loads mixed in
  task automatic test_random_traffic();
    logic [SIZE_W-1:0] sz;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       sz = SIZE_W'(1);
        1:       sz = SIZE_W'(DEPTH);
        2:       sz = SIZE_W'(200);
        default: sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 255))
                                                  : SIZE_W'($urandom_range(1, DEPTH));
      endcase
      write_size(sz);
      idle_on = (p < PHASES - 2);
      if (p % 2 == 0) reload_sorted();
      else scatter_loads(24);
      for (int k = 0; k < PHASE_SEARCHES; k++) begin
        if (p % 2 == 1 && $urandom_range(0, 9) == 0)
          load_entry(INDEX_W'($urandom_range(0, DEPTH - 1)), random_value());
        search_key(pick_key(), mode_t'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    item_ch.valid       = 1'b0;
    item_ch.command     = CMD_LOAD;
    item_ch.entry_index = '0;
    item_ch.data_value  = '0;
    item_ch.search_mode = MODE_LINEAR;
    res_ch.ready        = 1'b0;
    size_setting        = SIZE_RESET;
    idle_on             = 1'b1;
    stall_left          = 0;
    cycle_count         = 0;
    errors              = 0;
    n_searches          = 0;
    n_loads             = 0;
    n_checked           = 0;
    n_sizes             = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_edge_searches();
    test_size_corners();
    test_random_traffic();

    item_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (BLOCK_LATENCY) @(posedge clk);

    $display("Ran %0d searches in all four modes and %0d table loads over %0d size settings.",
             n_searches, n_loads, n_sizes);
    $display("Checked %0d result words, %0d field errors.", n_checked, errors);
    if (errors == 0) begin
      $display("table_search_comparison_counter_unit: match");
    end else begin
      $display("table_search_comparison_counter_unit: mismatch");
    end
    $finish;
  end

endmodule
